[sv/bencode_byte_tokenizer_assert.svh]
// assertion macros for the bencode byte tokenizer
`ifndef BENCODE_BYTE_TOKENIZER_ASSERT_SVH
`define BENCODE_BYTE_TOKENIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bencode tokenizer check failed");

// next-cycle implication, sampled on clk, off during reset
`define BBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bencode tokenizer check failed");

`endif

[sv/bbt_pkg.sv]
// shared types, codes and constants of the bencode byte tokenizer
package bbt_pkg;

	localparam int LENGTH_BITS_DEF  = 31;
	localparam int INTEGER_BITS_DEF = 64;
	localparam int NUMBER_W         = 64;
	localparam int QDEPTH           = 4;
	localparam int QPTR_W           = $clog2(QDEPTH);
	localparam int QCNT_W           = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_I     = 8'h69;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		TK_MARKER   = 3'd0,
		TK_INTEGER  = 3'd1,
		TK_STR_HDR  = 3'd2,
		TK_STR_BYTE = 3'd3,
		TK_EMPTY    = 3'd4,
		TK_ERROR    = 3'd5
	} tok_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_TOO_LONG = 3'd1,
		ERR_LEAD0    = 3'd2,
		ERR_INVALID  = 3'd3,
		ERR_OVERFLOW = 3'd4
	} err_code_t;

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_MINUS  = 3'd1,
		MODE_DIGITS = 3'd2,
		MODE_STRING = 3'd3,
		MODE_DROP   = 3'd4
	} lex_mode_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} byte_beat_t;

	typedef struct packed {
		tok_kind_t                   token_kind;
		logic [7:0]                  byte_value;
		logic signed [NUMBER_W-1:0]  number;
		logic                        string_end;
		err_code_t                   error_code;
		logic                        stream_done;
		logic                        last_of_item;
	} token_t;

	// up to two tokens written into the result queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} tok_push_t;

	function automatic token_t make_token(tok_kind_t kind, logic [7:0] bv,
			logic [NUMBER_W-1:0] num, logic send, err_code_t err);
		token_t t;
		t.token_kind   = kind;
		t.byte_value   = bv;
		t.number       = num;
		t.string_end   = send;
		t.error_code   = err;
		t.stream_done  = (err != ERR_NONE);
		t.last_of_item = 1'b0;
		return t;
	endfunction

endpackage

[sv/bencode_byte_tokenizer.sv]
// bencode byte tokenizer: one byte per beat in, one token per beat out
// a byte is registered in the input stage and its tokens in the result queue
// throughput: one byte per cycle while each byte gives at most one token
// and the result port is not stalled; the two tokens of one byte leave
// one per beat through a four-entry result queue and the single-beat port
// reset: arst_n clears the lexer state, the input stage and the result queue
module bencode_byte_tokenizer #(
	parameter int LENGTH_BITS  = bbt_pkg::LENGTH_BITS_DEF,
	parameter int INTEGER_BITS = bbt_pkg::INTEGER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  bbt_pkg::byte_beat_t byte_data,
	output logic                token_valid,
	input  logic                token_stall,
	output bbt_pkg::token_t     token_data
);
	import bbt_pkg::*;

	logic       vld_s1;
	byte_beat_t beat_s1;
	logic       room;
	logic       step;
	tok_push_t  push;

	assign step       = vld_s1 && room;
	assign byte_stall = vld_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (!byte_stall)
			vld_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (!byte_stall)
			beat_s1 <= byte_data;
	end

	bbt_lexer #(
		.LENGTH_BITS  (LENGTH_BITS),
		.INTEGER_BITS (INTEGER_BITS)
	) u_lexer (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.beat   (beat_s1),
		.push   (push)
	);

	bbt_out_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

endmodule

[sv/bbt_lexer.sv]
// lexer state and the per-byte token decision
module bbt_lexer #(
	parameter int LENGTH_BITS  = bbt_pkg::LENGTH_BITS_DEF,
	parameter int INTEGER_BITS = bbt_pkg::INTEGER_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  bbt_pkg::byte_beat_t beat,
	output bbt_pkg::tok_push_t  push
);
	import bbt_pkg::*;

	localparam int AW = (INTEGER_BITS > LENGTH_BITS) ? INTEGER_BITS : LENGTH_BITS;
	localparam int WW = AW + 4;
	localparam logic [WW-1:0] INT_MAG = WW'(1) << (INTEGER_BITS - 1);
	localparam logic [WW-1:0] LEN_MAX = (WW'(1) << LENGTH_BITS) - WW'(1);
	localparam logic [WW-1:0] ACC_CAP = (INT_MAG > LEN_MAX) ? INT_MAG : LEN_MAX;

	lex_mode_t              mode_q, mode_n;
	logic [AW-1:0]          acc_q, acc_n;
	logic                   minus_q, minus_n;
	logic                   fdz_q, fdz_n;
	logic                   motd_q, motd_n;
	logic                   ovf_q, ovf_n;
	logic [LENGTH_BITS-1:0] left_q, left_n;

	logic [7:0]    b;
	logic          eos;
	logic          digit;
	logic [WW-1:0] acc_wide;
	logic [WW-1:0] acc_x10;

	assign b        = beat.data_byte;
	assign eos      = beat.end_of_stream;
	assign digit    = (b >= CH_ZERO) && (b <= CH_NINE);
	assign acc_wide = WW'(acc_q);
	// times ten plus digit, as two shifts and two adds
	assign acc_x10  = (acc_wide << 3) + (acc_wide << 1) + WW'(b[3:0]);

	// closes a digit run as an integer or as an error
	function automatic token_t finish_int(logic [AW-1:0] acc, logic minus, logic fdz,
			logic motd, logic ovf);
		logic [NUMBER_W-1:0] mag;
		token_t t;
		mag = NUMBER_W'(acc);
		if (fdz && (motd || minus))
			t = make_token(TK_ERROR, 8'd0, '0, 1'b0, ERR_LEAD0);
		else if (ovf || (!minus && (WW'(acc) > (INT_MAG - WW'(1)))))
			t = make_token(TK_ERROR, 8'd0, '0, 1'b0, ERR_OVERFLOW);
		else
			t = make_token(TK_INTEGER, 8'd0, minus ? ('0 - mag) : mag, 1'b0, ERR_NONE);
		return t;
	endfunction

	always_comb begin
		token_t                 tok;
		token_t                 r0;
		token_t                 r1;
		logic [1:0]             n;
		logic                   err;
		logic                   fresh;
		logic [LENGTH_BITS-1:0] left_dec;

		mode_n   = mode_q;
		acc_n    = acc_q;
		minus_n  = minus_q;
		fdz_n    = fdz_q;
		motd_n   = motd_q;
		ovf_n    = ovf_q;
		left_n   = left_q;
		tok      = '0;
		r0       = '0;
		r1       = '0;
		n        = 2'd0;
		err      = 1'b0;
		fresh    = 1'b0;
		left_dec = (left_q != '0) ? (left_q - LENGTH_BITS'(1)) : left_q;

		unique case (mode_q)
			MODE_STRING: begin
				left_n = left_dec;
				tok = make_token(TK_STR_BYTE, b, '0, (left_dec == '0), ERR_NONE);
				if (left_dec == '0)
					mode_n = MODE_IDLE;
				r0 = tok;
				n = 2'd1;
			end
			MODE_MINUS: begin
				if (digit) begin
					mode_n = MODE_DIGITS;
					acc_n = AW'(b[3:0]);
					fdz_n = (b == CH_ZERO);
				end else begin
					r0 = make_token(TK_ERROR, b, '0, 1'b0, ERR_INVALID);
					n = 2'd1;
					err = 1'b1;
					mode_n = MODE_DROP;
				end
			end
			MODE_DIGITS: begin
				if (digit) begin
					motd_n = 1'b1;
					if (!ovf_q) begin
						if (acc_x10 > ACC_CAP)
							ovf_n = 1'b1;
						else
							acc_n = AW'(acc_x10);
					end
				end else if ((b == CH_COLON) && !minus_q) begin
					mode_n = MODE_IDLE;
					n = 2'd1;
					if (ovf_q || (acc_wide > LEN_MAX)) begin
						r0 = make_token(TK_ERROR, 8'd0, '0, 1'b0, ERR_OVERFLOW);
						err = 1'b1;
						mode_n = MODE_DROP;
					end else if (acc_q == '0) begin
						r0 = make_token(TK_EMPTY, 8'd0, '0, 1'b1, ERR_NONE);
					end else begin
						r0 = make_token(TK_STR_HDR, 8'd0, NUMBER_W'(acc_q), 1'b0, ERR_NONE);
						left_n = LENGTH_BITS'(acc_q);
						mode_n = MODE_STRING;
					end
				end else begin
					r0 = finish_int(acc_q, minus_q, fdz_q, motd_q, ovf_q);
					n = 2'd1;
					err = (r0.token_kind == TK_ERROR);
					mode_n = err ? MODE_DROP : MODE_IDLE;
					fresh = !err;
				end
			end
			MODE_IDLE: fresh = 1'b1;
			MODE_DROP: ;
			default: ;
		endcase

		// byte that starts a new token
		if (fresh) begin
			tok = '0;
			if ((b == CH_I) || (b == CH_D) || (b == CH_E) || (b == CH_L)) begin
				tok = make_token(TK_MARKER, b, '0, 1'b0, ERR_NONE);
			end else if (digit) begin
				mode_n  = MODE_DIGITS;
				acc_n   = AW'(b[3:0]);
				minus_n = 1'b0;
				fdz_n   = (b == CH_ZERO);
				motd_n  = 1'b0;
				ovf_n   = 1'b0;
			end else if (b == CH_MINUS) begin
				mode_n  = MODE_MINUS;
				acc_n   = '0;
				minus_n = 1'b1;
				fdz_n   = 1'b0;
				motd_n  = 1'b0;
				ovf_n   = 1'b0;
			end else begin
				tok = make_token(TK_ERROR, b, '0, 1'b0, ERR_INVALID);
				err = 1'b1;
				mode_n = MODE_DROP;
			end
			if ((tok.token_kind == TK_MARKER && !digit && b != CH_MINUS) || err) begin
				if (n == 2'd0)
					r0 = tok;
				else
					r1 = tok;
				n = n + 2'd1;
			end
		end

		// stream ends with a token still open
		if (eos && !err) begin
			tok = '0;
			if (mode_n == MODE_DIGITS)
				tok = finish_int(acc_n, minus_n, fdz_n, motd_n, ovf_n);
			else if (mode_n == MODE_MINUS)
				tok = make_token(TK_ERROR, b, '0, 1'b0, ERR_INVALID);
			else if (mode_n == MODE_STRING)
				tok = make_token(TK_ERROR, 8'd0, '0, 1'b0, ERR_TOO_LONG);
			if ((mode_n == MODE_DIGITS) || (mode_n == MODE_MINUS) ||
					(mode_n == MODE_STRING)) begin
				if (n == 2'd0)
					r0 = tok;
				else
					r1 = tok;
				if (n != 2'd2)
					n = n + 2'd1;
			end
		end

		if (n == 2'd1) begin
			r0.last_of_item = 1'b1;
			r0.stream_done  = r0.stream_done | eos;
		end else if (n == 2'd2) begin
			r1.last_of_item = 1'b1;
			r1.stream_done  = r1.stream_done | eos;
		end

		if (eos) begin
			mode_n  = MODE_IDLE;
			acc_n   = '0;
			minus_n = 1'b0;
			fdz_n   = 1'b0;
			motd_n  = 1'b0;
			ovf_n   = 1'b0;
			left_n  = '0;
		end

		push.count  = step ? n : 2'd0;
		push.first  = r0;
		push.second = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			acc_q   <= '0;
			minus_q <= 1'b0;
			fdz_q   <= 1'b0;
			motd_q  <= 1'b0;
			ovf_q   <= 1'b0;
			left_q  <= '0;
		end else if (step) begin
			mode_q  <= mode_n;
			acc_q   <= acc_n;
			minus_q <= minus_n;
			fdz_q   <= fdz_n;
			motd_q  <= motd_n;
			ovf_q   <= ovf_n;
			left_q  <= left_n;
		end
	end

endmodule

[sv/bbt_out_queue.sv]
// result queue: takes up to two tokens a cycle, hands out one beat a cycle while the result port is not stalled
module bbt_out_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  bbt_pkg::tok_push_t push,
	output logic               room,
	output logic               token_valid,
	input  logic               token_stall,
	output bbt_pkg::token_t    token_data
);
	import bbt_pkg::*;

	token_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wp_q;
	logic [QPTR_W-1:0] rp_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign token_valid = (count_q != '0);
	assign pop         = token_valid && !token_stall;
	assign token_data  = mem[rp_q];
	// room for the worst case of two tokens from one byte
	assign room        = (count_q <= QCNT_W'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wp_q] <= push.first;
		if (push.count == 2'd2)
			mem[wp_q + QPTR_W'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + QPTR_W'(push.count);
			rp_q    <= rp_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

[sv/bbt_checker.sv]
// port-level checks of the tokenizer's result channel, bound to the top level
`include "bencode_byte_tokenizer_assert.svh"

module bbt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            token_valid,
	input logic            token_stall,
	input bbt_pkg::token_t token_data
);
	import bbt_pkg::*;

	// a stalled beat stays put
	`BBT_ASSERT_NEXT(a_hold, token_valid && token_stall, token_valid && $stable(token_data))

	// nothing follows an error in its stream, so it closes both item and stream
	`BBT_ASSERT_NOW(a_err_closes, token_valid && (token_data.token_kind == TK_ERROR), token_data.stream_done && token_data.last_of_item && (token_data.error_code != ERR_NONE))

	// error code only rides on error tokens
	`BBT_ASSERT_NOW(a_code_on_err, token_valid && (token_data.token_kind != TK_ERROR), token_data.error_code == ERR_NONE)

	// string end flag only on a string byte or an empty string
	`BBT_ASSERT_NOW(a_str_end, token_valid && token_data.string_end, (token_data.token_kind == TK_STR_BYTE) || (token_data.token_kind == TK_EMPTY))

endmodule

bind bencode_byte_tokenizer bbt_checker u_bbt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_data  (token_data)
);
